// ----- rtl/lcic_pkg.sv -----
`default_nettype none
package lcic_pkg;

	localparam int AXIS_SLOTS   = 4;
	localparam int DEF_MAX_AXES = 4;
	localparam int LINE_W       = 32;
	localparam int COORD_W      = 16;
	localparam int EXT_W        = COORD_W + 1;
	localparam int CFG_IDX_W    = 3;
	localparam int AXES_W       = 3;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_AXES   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS3 = 3'd4;

	typedef struct packed {
		logic                                   action;
		logic [LINE_W-1:0]                      d;
		logic [EXT_W-1:0]                       r;
		logic [LINE_W-1:0]                      line;
		logic [AXIS_SLOTS-1:0][COORD_W-1:0]     coord_in;
		logic [AXIS_SLOTS-1:0][COORD_W-1:0]     coord_out;
	} lcic_item_t;

	// A size register of zero stands for an extent of 65536.
	function automatic logic [EXT_W-1:0] ext_of(input logic [COORD_W-1:0] size);
		ext_of = (size == '0) ? {1'b1, {COORD_W{1'b0}}} : {1'b0, size};
	endfunction

endpackage
`default_nettype wire

// ----- rtl/lcic_cell.sv -----
`default_nettype none
module lcic_cell (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      en,
	input  wire                      in_v,
	input  lcic_pkg::lcic_item_t     in_item,
	input  wire [lcic_pkg::EXT_W-1:0] ext,
	output logic                     out_v,
	output lcic_pkg::lcic_item_t     out_item
);

	logic [lcic_pkg::EXT_W:0] tr;
	logic [lcic_pkg::EXT_W:0] diff;
	logic                     ge;
	lcic_pkg::lcic_item_t     nxt;

	// One restoring division step: the dividend shifts out at the top while
	// quotient bits enter at the bottom.
	always_comb begin
		tr   = {in_item.r, in_item.d[lcic_pkg::LINE_W-1]};
		ge   = tr >= {1'b0, ext};
		diff = tr - {1'b0, ext};
		nxt  = in_item;
		nxt.r = ge ? diff[lcic_pkg::EXT_W-1:0] : tr[lcic_pkg::EXT_W-1:0];
		nxt.d = {in_item.d[lcic_pkg::LINE_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item <= nxt;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/lcic_axis.sv -----
`default_nettype none
module lcic_axis #(
	parameter int MAX_AXES = lcic_pkg::DEF_MAX_AXES,
	parameter int AXIS     = 0
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       en,
	input  wire                       in_v,
	input  lcic_pkg::lcic_item_t      in_item,
	input  wire [lcic_pkg::EXT_W-1:0] ext_split,
	input  wire [lcic_pkg::EXT_W-1:0] ext_build,
	input  wire                       use_split,
	input  wire                       use_build,
	output logic                      out_v,
	output lcic_pkg::lcic_item_t      out_item
);

	localparam int STEPS = lcic_pkg::LINE_W;
	localparam int BA    = MAX_AXES - 1 - AXIS;

	lcic_pkg::lcic_item_t          pre;
	lcic_pkg::lcic_item_t          stg [0:STEPS];
	logic [STEPS:0]                vv;
	logic [lcic_pkg::LINE_W+lcic_pkg::EXT_W-1:0] prod;

	// The rebuild runs the axes slowest first, so this stage folds in axis BA.
	always_comb begin
		prod = in_item.line * ext_build;
		pre  = in_item;
		pre.r = '0;
		if (use_build) begin
			pre.line = prod[lcic_pkg::LINE_W-1:0]
				+ {{(lcic_pkg::LINE_W-lcic_pkg::COORD_W){1'b0}}, in_item.coord_in[BA]};
		end
	end

	assign stg[0] = pre;
	assign vv[0]  = in_v;

	for (genvar i = 0; i < STEPS; i++) begin : g_cell
		lcic_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_v     (vv[i]),
			.in_item  (stg[i]),
			.ext      (ext_split),
			.out_v    (vv[i+1]),
			.out_item (stg[i+1])
		);
	end

	always_comb begin
		out_item = stg[STEPS];
		out_item.coord_out[AXIS] = use_split ? stg[STEPS].r[lcic_pkg::COORD_W-1:0] : '0;
	end
	assign out_v = vv[STEPS];

endmodule
`default_nettype wire

// ----- rtl/linear_cartesian_index_convert.sv -----
`default_nettype none
// Linear index <-> per-axis coordinate converter for a box of up to MAX_AXES axes.
// Input items arrive on s_tvalid/s_tready/s_tdata/s_tuser; s_tuser is the action:
// 0 splits s_tdata's linear index into coordinates, 1 rebuilds the index from the
// coordinates. Results leave on m_tvalid/m_tready/m_tdata, one per input item.
// The configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
// axis count (index 0) and the axis extents (indexes 1 to 4); write it only while
// no item is in flight. It is always ready.
// Each axis is a chain of 32 division cells, one quotient bit per cell, and the
// rebuild multiply-add for one axis sits at the head of each chain. An item passes
// the registered cells of every axis and then the output register on its way to
// m_tvalid, and one item is accepted in every cycle while s_tready is high.
// When m_tready is low, one more result is caught in a skid register; after that
// the whole chain holds and s_tready goes low until the skid register drains.
// Reset returns one axis of extent 1 on every axis and empties the chain.
module linear_cartesian_index_convert #(
	parameter int MAX_AXES = lcic_pkg::DEF_MAX_AXES
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire [95:0]  s_tdata,   // line_index, coord0, coord1, coord2, coord3
	input  wire         s_tuser,   // action
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [95:0] m_tdata,   // line_out, coord_out0, coord_out1, coord_out2, coord_out3
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire [lcic_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [15:0]  cfg_data
);

	logic [lcic_pkg::AXES_W-1:0]  num_axes_q;
	logic [lcic_pkg::AXES_W-1:0]  n_use;
	logic [lcic_pkg::AXIS_SLOTS-1:0][lcic_pkg::COORD_W-1:0] size_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_axes_q <= lcic_pkg::AXES_W'(1);
			size_q     <= {lcic_pkg::AXIS_SLOTS{lcic_pkg::COORD_W'(1)}};
		end else if (cfg_valid) begin
			case (cfg_index)
				lcic_pkg::REG_NUM_AXES:   num_axes_q <= cfg_data[lcic_pkg::AXES_W-1:0];
				lcic_pkg::REG_SIZE_AXIS0: size_q[0] <= cfg_data;
				lcic_pkg::REG_SIZE_AXIS1: size_q[1] <= cfg_data;
				lcic_pkg::REG_SIZE_AXIS2: size_q[2] <= cfg_data;
				lcic_pkg::REG_SIZE_AXIS3: size_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign n_use = (num_axes_q > lcic_pkg::AXES_W'(MAX_AXES))
		? lcic_pkg::AXES_W'(MAX_AXES) : num_axes_q;

	logic                 skid_v_q, out_v_q, en, take;
	lcic_pkg::lcic_item_t chain [0:MAX_AXES];
	logic [MAX_AXES:0]    cv;
	logic [95:0]          skid_q, out_q, p_data;

	assign en       = !skid_v_q;
	assign s_tready = en;

	always_comb begin
		chain[0]           = '0;
		chain[0].action    = s_tuser;
		chain[0].d         = s_tdata[31:0];
		chain[0].coord_in  = s_tdata[95:32];
	end
	assign cv[0] = s_tvalid;

	for (genvar k = 0; k < MAX_AXES; k++) begin : g_axis
		localparam int BA = MAX_AXES - 1 - k;
		lcic_axis #(
			.MAX_AXES (MAX_AXES),
			.AXIS     (k)
		) u_axis (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_v      (cv[k]),
			.in_item   (chain[k]),
			.ext_split (lcic_pkg::ext_of(size_q[k])),
			.ext_build (lcic_pkg::ext_of(size_q[BA])),
			.use_split (lcic_pkg::AXES_W'(k) < n_use),
			.use_build (lcic_pkg::AXES_W'(BA) < n_use),
			.out_v     (cv[k+1]),
			.out_item  (chain[k+1])
		);
	end

	assign p_data = chain[MAX_AXES].action
		? {64'd0, chain[MAX_AXES].line}
		: {chain[MAX_AXES].coord_out, 32'd0};

	assign take = out_v_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				skid_v_q <= 1'b0;
			end
		end else if (cv[MAX_AXES]) begin
			if (!out_v_q || take) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (cv[MAX_AXES]) begin
			if (!out_v_q || take) begin
				out_q <= p_data;
			end else begin
				skid_q <= p_data;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

endmodule
`default_nettype wire
